// ===== rtl/core/swet_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swet_pkg: shared constants, sine tables and helpers
// Window geometry, phase reduction sizing, register indices and reset values,
// the quarter-wave sine magnitude tables built at elaboration, and ring
// arithmetic.
// ----------------------------------------------------------------------------
package swet_pkg;

    localparam int WINDOW_DEPTH    = 128;
    localparam int SLOT_W          = $clog2(WINDOW_DEPTH);
    localparam int CNT_W           = SLOT_W + 1;
    localparam int SUM_W           = CNT_W + 1;
    localparam int CMP_W           = (CNT_W > 8) ? CNT_W : 8;
    localparam int POINT_W         = 48;

    localparam int SINE_TABLE_SIZE = 1024;
    localparam int K_W             = $clog2(SINE_TABLE_SIZE);
    localparam int QTR             = SINE_TABLE_SIZE / 4;
    localparam int QTR_W           = K_W - 2;

    // The table index is floor((phase >> 17) / 45) modulo the table size,
    // 360 being 8 * 45; the division is a multiplication by a rounded-up
    // reciprocal, which is exact over the whole range of the shifted phase.
    localparam int PH_W            = 48;
    localparam int DIV_DEN         = 45;
    localparam int DIV_SH          = 24 - K_W + 3;
    localparam int DIV_W           = PH_W - DIV_SH;
    localparam int RECIP_SH        = DIV_W + $clog2(DIV_DEN);
    localparam int RECIP_W         = 32;
    localparam int PROD_W          = DIV_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SH) + 64'(DIV_DEN - 1)) / 64'(DIV_DEN));

    localparam logic [2:0] CFG_AMPLITUDE       = 3'd0;
    localparam logic [2:0] CFG_FREQUENCY       = 3'd1;
    localparam logic [2:0] CFG_SAMPLE_INTERVAL = 3'd2;
    localparam logic [2:0] CFG_WINDOW_LENGTH   = 3'd3;
    localparam logic [2:0] CFG_READ_ENABLE     = 3'd4;

    localparam logic signed [15:0] AMP_RST      = 16'sd256;
    localparam logic [15:0]        FREQ_RST     = 16'd256;
    localparam logic [31:0]        INTERVAL_RST = 32'd6554;
    localparam logic [7:0]         WLEN_RST     = 8'd100;

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] Q30_PI      = 64'd3373259426;
    localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

    typedef logic [14:0] t_sine_tab [QTR];

    function automatic logic [14:0] sine_mag(input int unsigned k);
        logic [63:0]        th;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        mag;
        th = (64'(k) * (2 * Q30_PI)) / SINE_TABLE_SIZE;
        if (th >= Q30_PI) begin
            th = th - Q30_PI;
        end
        if (th > Q30_HALF_PI) begin
            th = Q30_PI - th;
        end
        x2   = (th * th) >> 30;
        term = th;
        sum  = $signed(th);
        term = ((term * x2) >> 30) / 6;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 20;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 42;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 72;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 110;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 156;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 210;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 272;
        sum  = sum + $signed(term);
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > $signed(Q30_ONE)) begin
            sum = $signed(Q30_ONE);
        end
        mag = (64'(sum) * 64'd32767 + 64'd536870912) >> 30;
        return mag[14:0];
    endfunction

    function automatic t_sine_tab build_tab(input int unsigned base);
        t_sine_tab tab;
        for (int j = 0; j < QTR; j++) begin
            tab[j] = sine_mag(base + 32'(j));
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_LO = build_tab(0);
    localparam t_sine_tab SINE_HI = build_tab(QTR);

    function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] base,
                                                  input logic [CNT_W-1:0]  off);
        logic [SUM_W-1:0] s;
        s = {2'b00, base} + {1'b0, off};
        if (s >= SUM_W'(WINDOW_DEPTH)) begin
            s = s - SUM_W'(WINDOW_DEPTH);
        end
        return s[SLOT_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/swet_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swet_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module swet_ram #(
    parameter int  WIDTH = 48,
    parameter int  DEPTH = 128,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/core/sine_window_extremes_tracker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sine_window_extremes_tracker: sliding window of sine samples with extremes
// Samples a sine on timestamp ticks into a ring of points held in RAM and
// reports the window's first and last x and its least and greatest y.
// ----------------------------------------------------------------------------
// Usage. An input word is taken when i_in_valid is high and o_in_stall low.
// A tick (mode 0) whose timestamp has advanced by at least the sample interval
// appends a point and yields one result word of kind 0; any other tick yields
// nothing. A read (mode 1) always yields one result word of kind 1.
// A tick reduces the phase by a reciprocal multiplication and appends its
// point; then every point is read back through the single RAM read port,
// one per cycle, to find the extremes. A read with an index beyond the
// window, or with reads disabled, returns a zero point. One word is worked
// on at a time; o_in_stall is high from acceptance until the result has moved
// into the output register, which lets the next word in while a result waits.
// A held result stays unchanged while i_out_stall is high.
// Reset empties the window and restores the register defaults; the point
// memory itself is not cleared. Registers are written through the i_cfg_*
// channel, which is always ready; the user must write them only while the
// block is idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module sine_window_extremes_tracker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_mode,
    input  wire logic [31:0]        i_time_stamp,
    input  wire logic [6:0]         i_read_index,

    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic                    o_kind,
    output logic [31:0]             o_point_x,
    output logic signed [15:0]      o_point_y,
    output logic [31:0]             o_window_x_first,
    output logic [31:0]             o_window_x_last,
    output logic signed [15:0]      o_window_y_low,
    output logic signed [15:0]      o_window_y_high,
    output logic [7:0]              o_fill_count,

    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data
);

    localparam int SLOT_W   = swet_pkg::SLOT_W;
    localparam int CNT_W    = swet_pkg::CNT_W;
    localparam int CMP_W    = swet_pkg::CMP_W;
    localparam int K_W      = swet_pkg::K_W;
    localparam int QTR_W    = swet_pkg::QTR_W;
    localparam int DIV_W    = swet_pkg::DIV_W;
    localparam int RECIP_SH = swet_pkg::RECIP_SH;
    localparam int PROD_W   = swet_pkg::PROD_W;
    localparam int PH_W     = swet_pkg::PH_W;
    localparam int PW       = swet_pkg::POINT_W;

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_DECODE   = 10'b00_0000_0010,
        S_DIV      = 10'b00_0000_0100,
        S_SINE     = 10'b00_0000_1000,
        S_PROD     = 10'b00_0001_0000,
        S_ROUND    = 10'b00_0010_0000,
        S_SCAN     = 10'b00_0100_0000,
        S_SCAN_END = 10'b00_1000_0000,
        S_READ     = 10'b01_0000_0000,
        S_DONE     = 10'b10_0000_0000
    } t_state;

    // Configuration registers.
    logic signed [15:0] r_amp;
    logic [15:0]        r_freq;
    logic [31:0]        r_interval;
    logic [7:0]         r_wlen;
    logic               r_rd_en;

    // Control and window state.
    t_state             r_state, n_state;
    logic               r_mode, n_mode;
    logic [31:0]        r_t, n_t;
    logic [6:0]         r_idx, n_idx;
    logic [31:0]        r_last, n_last;
    logic [SLOT_W-1:0]  r_oldest, n_oldest;
    logic [CNT_W-1:0]   r_held, n_held;
    logic [31:0]        r_x_first, n_x_first;
    logic [31:0]        r_x_last, n_x_last;
    logic signed [15:0] r_y_low, n_y_low;
    logic signed [15:0] r_y_high, n_y_high;
    logic [CNT_W-1:0]   r_sidx, n_sidx;
    logic               r_pend, n_pend;
    logic               r_pfirst, n_pfirst;
    logic               r_out_valid, n_out_valid;

    // Datapath registers.
    logic [DIV_W-1:0]   r_num, n_num;
    logic [K_W-1:0]     r_q, n_q;
    logic signed [15:0] r_entry, n_entry;
    logic signed [31:0] r_prod, n_prod;
    logic [31:0]        r_px, n_px;
    logic signed [15:0] r_py, n_py;

    // Output word.
    logic               r_o_kind, n_o_kind;
    logic [31:0]        r_o_px, n_o_px;
    logic signed [15:0] r_o_py, n_o_py;
    logic [31:0]        r_o_xf, n_o_xf;
    logic [31:0]        r_o_xl, n_o_xl;
    logic signed [15:0] r_o_yl, n_o_yl;
    logic signed [15:0] r_o_yh, n_o_yh;
    logic [7:0]         r_o_fill, n_o_fill;

    // Combinational helpers.
    logic [CMP_W-1:0]   wl_c;
    logic [CNT_W-1:0]   wl_eff;
    logic               tick_ok;
    logic               idx_ok;
    logic [PH_W-1:0]    ph;
    logic [PROD_W-1:0]  quo_prod;
    logic [14:0]        sine_mag;
    logic [15:0]        mag_ext;
    logic [15:0]        sine_val;
    logic signed [32:0] rnd_sum;
    logic signed [17:0] rnd_q;
    logic signed [15:0] y_sat;
    logic               out_free;

    // RAM port.
    logic               ram_we;
    logic [SLOT_W-1:0]  ram_waddr;
    logic [PW-1:0]      ram_wdata;
    logic [SLOT_W-1:0]  ram_raddr;
    logic [PW-1:0]      ram_rdata;
    logic [31:0]        rd_x;
    logic signed [15:0] rd_y;

    swet_ram #(
        .WIDTH (PW),
        .DEPTH (swet_pkg::WINDOW_DEPTH)
    ) u_points (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_x = ram_rdata[PW-1:16];
    assign rd_y = ram_rdata[15:0];

    always_comb begin
        wl_c = CMP_W'(r_wlen);
        if (wl_c == '0) begin
            wl_c = CMP_W'(1);
        end else if (wl_c > CMP_W'(swet_pkg::WINDOW_DEPTH)) begin
            wl_c = CMP_W'(swet_pkg::WINDOW_DEPTH);
        end
        wl_eff = wl_c[CNT_W-1:0];
    end

    assign tick_ok = (r_t >= r_last) && ((r_t - r_last) >= r_interval);
    assign idx_ok  = r_rd_en && (CMP_W'(r_idx) < CMP_W'(r_held));
    assign ph      = r_freq * r_t;

    assign quo_prod = r_num * swet_pkg::RECIP;

    assign sine_mag = r_q[K_W-2] ? swet_pkg::SINE_HI[r_q[QTR_W-1:0]]
                                 : swet_pkg::SINE_LO[r_q[QTR_W-1:0]];
    assign mag_ext  = {1'b0, sine_mag};
    assign sine_val = r_q[K_W-1] ? (16'd0 - mag_ext) : mag_ext;

    always_comb begin
        rnd_sum = {r_prod[31], r_prod} + 33'sd16384;
        rnd_q   = $signed(rnd_sum[32:15]);
        if (rnd_q > 18'sd32767) begin
            y_sat = 16'sh7FFF;
        end else if (rnd_q < -18'sd32768) begin
            y_sat = 16'sh8000;
        end else begin
            y_sat = rnd_q[15:0];
        end
    end

    assign out_free  = !r_out_valid || !i_out_stall;
    assign ram_we    = (r_state == S_ROUND);
    assign ram_waddr = swet_pkg::slot_add(r_oldest, r_held);
    assign ram_wdata = {r_t, y_sat};
    assign ram_raddr = (r_state == S_DECODE) ? swet_pkg::slot_add(r_oldest, CNT_W'(r_idx))
                                             : swet_pkg::slot_add(r_oldest, r_sidx);

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_t         = r_t;
        n_idx       = r_idx;
        n_last      = r_last;
        n_oldest    = r_oldest;
        n_held      = r_held;
        n_x_first   = r_x_first;
        n_x_last    = r_x_last;
        n_y_low     = r_y_low;
        n_y_high    = r_y_high;
        n_sidx      = r_sidx;
        n_pend      = 1'b0;
        n_pfirst    = r_pfirst;
        n_out_valid = r_out_valid && i_out_stall;
        n_num       = r_num;
        n_q         = r_q;
        n_entry     = r_entry;
        n_prod      = r_prod;
        n_px        = r_px;
        n_py        = r_py;
        n_o_kind    = r_o_kind;
        n_o_px      = r_o_px;
        n_o_py      = r_o_py;
        n_o_xf      = r_o_xf;
        n_o_xl      = r_o_xl;
        n_o_yl      = r_o_yl;
        n_o_yh      = r_o_yh;
        n_o_fill    = r_o_fill;

        if (r_pend) begin
            if (r_pfirst) begin
                n_x_first = rd_x;
                n_y_low   = rd_y;
                n_y_high  = rd_y;
            end else begin
                if (rd_y < r_y_low) begin
                    n_y_low = rd_y;
                end
                if (rd_y > r_y_high) begin
                    n_y_high = rd_y;
                end
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_mode  = i_mode;
                    n_t     = i_time_stamp;
                    n_idx   = i_read_index;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_num = ph[PH_W-1:swet_pkg::DIV_SH];
                if (!r_mode) begin
                    if (tick_ok) begin
                        n_last = r_t;
                        if (r_held >= wl_eff) begin
                            n_oldest = swet_pkg::slot_add(r_oldest,
                                                          r_held - wl_eff + CNT_W'(1));
                            n_held   = wl_eff - CNT_W'(1);
                        end
                        n_state = S_DIV;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else if (idx_ok) begin
                    n_state = S_READ;
                end else begin
                    n_px    = '0;
                    n_py    = '0;
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                n_q     = quo_prod[RECIP_SH+K_W-1:RECIP_SH];
                n_state = S_SINE;
            end
            S_SINE: begin
                n_entry = sine_val;
                n_state = S_PROD;
            end
            S_PROD: begin
                n_prod  = r_amp * r_entry;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                n_px     = r_t;
                n_py     = y_sat;
                n_x_last = r_t;
                n_held   = r_held + CNT_W'(1);
                n_sidx   = '0;
                n_state  = S_SCAN;
            end
            S_SCAN: begin
                n_pend   = 1'b1;
                n_pfirst = (r_sidx == '0);
                if (r_sidx == r_held - CNT_W'(1)) begin
                    n_state = S_SCAN_END;
                end else begin
                    n_sidx = r_sidx + CNT_W'(1);
                end
            end
            S_SCAN_END: begin
                n_state = S_DONE;
            end
            S_READ: begin
                n_px    = rd_x;
                n_py    = rd_y;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_o_kind    = r_mode;
                    n_o_px      = r_px;
                    n_o_py      = r_py;
                    n_o_xf      = r_x_first;
                    n_o_xl      = r_x_last;
                    n_o_yl      = r_y_low;
                    n_o_yh      = r_y_high;
                    n_o_fill    = 8'(r_held);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp      <= swet_pkg::AMP_RST;
            r_freq     <= swet_pkg::FREQ_RST;
            r_interval <= swet_pkg::INTERVAL_RST;
            r_wlen     <= swet_pkg::WLEN_RST;
            r_rd_en    <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                swet_pkg::CFG_AMPLITUDE:       r_amp      <= i_cfg_data[15:0];
                swet_pkg::CFG_FREQUENCY:       r_freq     <= i_cfg_data[15:0];
                swet_pkg::CFG_SAMPLE_INTERVAL: r_interval <= i_cfg_data;
                swet_pkg::CFG_WINDOW_LENGTH:   r_wlen     <= i_cfg_data[7:0];
                swet_pkg::CFG_READ_ENABLE:     r_rd_en    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last      <= '0;
            r_oldest    <= '0;
            r_held      <= '0;
            r_x_first   <= '0;
            r_x_last    <= '0;
            r_y_low     <= '0;
            r_y_high    <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_last      <= n_last;
            r_oldest    <= n_oldest;
            r_held      <= n_held;
            r_x_first   <= n_x_first;
            r_x_last    <= n_x_last;
            r_y_low     <= n_y_low;
            r_y_high    <= n_y_high;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_t      <= n_t;
        r_idx    <= n_idx;
        r_sidx   <= n_sidx;
        r_pfirst <= n_pfirst;
        r_num    <= n_num;
        r_q      <= n_q;
        r_entry  <= n_entry;
        r_prod   <= n_prod;
        r_px     <= n_px;
        r_py     <= n_py;
        r_o_kind <= n_o_kind;
        r_o_px   <= n_o_px;
        r_o_py   <= n_o_py;
        r_o_xf   <= n_o_xf;
        r_o_xl   <= n_o_xl;
        r_o_yl   <= n_o_yl;
        r_o_yh   <= n_o_yh;
        r_o_fill <= n_o_fill;
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_cfg_ready      = 1'b1;
    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_o_kind;
    assign o_point_x        = r_o_px;
    assign o_point_y        = r_o_py;
    assign o_window_x_first = r_o_xf;
    assign o_window_x_last  = r_o_xl;
    assign o_window_y_low   = r_o_yl;
    assign o_window_y_high  = r_o_yh;
    assign o_fill_count     = r_o_fill;

endmodule
`default_nettype wire

// ===== rtl/core/swet_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swet_checker: port-level checks for the sine window tracker
// Watches the handshakes and the consistency of each result word.
// ----------------------------------------------------------------------------
module swet_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire logic               o_kind,
    input wire logic [31:0]        o_point_x,
    input wire logic signed [15:0] o_point_y,
    input wire logic [31:0]        o_window_x_last,
    input wire logic signed [15:0] o_window_y_low,
    input wire logic signed [15:0] o_window_y_high,
    input wire logic [7:0]         o_fill_count
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_point_x))
        else $error("Result word changed or vanished while stalled.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("A second word was taken while one is being worked on.");

    a_sample_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_kind |-> o_point_x == o_window_x_last
            && o_point_y >= o_window_y_low && o_point_y <= o_window_y_high)
        else $error("Appended sample lies outside the reported window.");

    a_window_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_fill_count <= swet_pkg::WINDOW_DEPTH
            && o_window_y_low <= o_window_y_high)
        else $error("Window count or extremes are inconsistent.");

endmodule

bind sine_window_extremes_tracker swet_checker u_swet_checker (.*);
`default_nettype wire
